// ===== rtl/lsi_pkg.sv =====
// lsi_pkg: shared types for the line segment intersection core
// no dependencies; used by lsi_out_if and the core
`default_nettype none

package lsi_pkg;

    // status flags that travel with each result
    typedef struct packed {
        logic hit;
        logic parallel;
        logic overflow;
    } t_lsi_flags;

endpackage

`default_nettype wire

// ===== rtl/lsi_in_if.sv =====
// lsi_in_if: request channel carrying two lines and the bounded mode bit
// depends on nothing; width follows COORD_WIDTH
`default_nettype none

interface lsi_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;
    logic                          bounded;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
        output b_start_x, b_start_y, b_end_x, b_end_y, bounded,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
        input  b_start_x, b_start_y, b_end_x, b_end_y, bounded,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/lsi_out_if.sv =====
// lsi_out_if: result channel carrying the point and status flags
// depends on lsi_pkg for the flag struct
`default_nettype none

interface lsi_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    lsi_pkg::t_lsi_flags           flags;

    modport source (output valid, point_x, point_y, flags, input ready);
    modport sink   (input valid, point_x, point_y, flags, output ready);
endinterface

`default_nettype wire

// ===== rtl/line_segment_intersection_core.sv =====
// line_segment_intersection_core: pipelined intersection point of two lines
// depends on lsi_pkg, lsi_in_if and lsi_out_if
//
// usage
//   i_req carries one request per accepted valid/ready pair: the start and
//   end points of lines A and B in signed fixed point plus the bounded bit.
//   o_res returns one result per request, in order: the saturated point,
//   hit, parallel and overflow.
//   the pipeline is the restoring divider, which resolves one quotient
//   bit per pipeline stage, plus eleven stages of differences, products,
//   sums, range check, final checks and output.
//   throughput: one request per cycle while the skid entry is empty.
//   the whole pipeline moves on one enable; an output register plus one
//   skid entry sit behind it, so a request is still taken while a result
//   waits. i_req.ready drops only once the skid entry is full, and nothing
//   in flight is lost or repeated while o_res.ready is low.
//   reset (i_rst_n low, synchronous) empties every stage, the output
//   register and the skid entry; payload registers are not cleared.
`default_nettype none

module line_segment_intersection_core #(
    parameter int COORD_WIDTH = 32
) (
    input wire        i_clk,
    input wire        i_rst_n,
    lsi_in_if.sink    i_req,
    lsi_out_if.source o_res
);

    localparam int C    = COORD_WIDTH;
    localparam int DW   = C + 1;        // coordinate difference
    localparam int PW   = 2 * DW;       // product of two differences
    localparam int DETW = PW + 1;       // determinant and t numerator
    localparam int LW   = C + 2;        // low slice of det / tn
    localparam int HW   = DETW - LW;    // high slice of det / tn
    localparam int NW   = 3 * C + 5;    // point numerator
    localparam int RW   = DETW + C;     // divider remainder
    localparam int BXW  = 8 * C + 1;    // segment boxes plus mode bit

    // global pipeline enable, skid entry empty
    logic en;
    logic r_sk_vld;
    assign en          = !r_sk_vld;
    assign i_req.ready = en;

    // segment boxes of the input lines
    logic signed [C-1:0]  w_xlo_a, w_xhi_a, w_ylo_a, w_yhi_a;
    logic signed [C-1:0]  w_xlo_b, w_xhi_b, w_ylo_b, w_yhi_b;
    always_comb begin
        w_xlo_a = (i_req.a_start_x < i_req.a_end_x) ? i_req.a_start_x : i_req.a_end_x;
        w_xhi_a = (i_req.a_start_x < i_req.a_end_x) ? i_req.a_end_x : i_req.a_start_x;
        w_ylo_a = (i_req.a_start_y < i_req.a_end_y) ? i_req.a_start_y : i_req.a_end_y;
        w_yhi_a = (i_req.a_start_y < i_req.a_end_y) ? i_req.a_end_y : i_req.a_start_y;
        w_xlo_b = (i_req.b_start_x < i_req.b_end_x) ? i_req.b_start_x : i_req.b_end_x;
        w_xhi_b = (i_req.b_start_x < i_req.b_end_x) ? i_req.b_end_x : i_req.b_start_x;
        w_ylo_b = (i_req.b_start_y < i_req.b_end_y) ? i_req.b_start_y : i_req.b_end_y;
        w_yhi_b = (i_req.b_start_y < i_req.b_end_y) ? i_req.b_end_y : i_req.b_start_y;
    end

    // stage 0: differences
    logic                 r_v0;
    logic signed [DW-1:0] r0_dax, r0_day, r0_dbx, r0_dby, r0_ex, r0_ey;
    logic signed [C-1:0]  r0_asx, r0_asy;
    logic [BXW-1:0]       r0_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_dax <= DW'(i_req.a_end_x) - DW'(i_req.a_start_x);
            r0_day <= DW'(i_req.a_end_y) - DW'(i_req.a_start_y);
            r0_dbx <= DW'(i_req.b_end_x) - DW'(i_req.b_start_x);
            r0_dby <= DW'(i_req.b_end_y) - DW'(i_req.b_start_y);
            r0_ex  <= DW'(i_req.b_start_x) - DW'(i_req.a_start_x);
            r0_ey  <= DW'(i_req.b_start_y) - DW'(i_req.a_start_y);
            r0_asx <= i_req.a_start_x;
            r0_asy <= i_req.a_start_y;
            r0_box <= {i_req.bounded, w_xlo_a, w_xhi_a, w_ylo_a, w_yhi_a,
                       w_xlo_b, w_xhi_b, w_ylo_b, w_yhi_b};
        end
    end

    // stage 1: cross products
    logic                 r_v1;
    logic signed [PW-1:0] r1_p0, r1_p1, r1_p2, r1_p3;
    logic signed [DW-1:0] r1_dax, r1_day;
    logic signed [C-1:0]  r1_asx, r1_asy;
    logic [BXW-1:0]       r1_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p0  <= r0_dax * r0_dby;
            r1_p1  <= r0_day * r0_dbx;
            r1_p2  <= r0_ex * r0_dby;
            r1_p3  <= r0_ey * r0_dbx;
            r1_dax <= r0_dax;
            r1_day <= r0_day;
            r1_asx <= r0_asx;
            r1_asy <= r0_asy;
            r1_box <= r0_box;
        end
    end

    // stage 2: determinant and t numerator
    logic                   r_v2;
    logic signed [DETW-1:0] r2_det, r2_tn;
    logic signed [DW-1:0]   r2_dax, r2_day;
    logic signed [C-1:0]    r2_asx, r2_asy;
    logic [BXW-1:0]         r2_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_det <= DETW'(r1_p0) - DETW'(r1_p1);
            r2_tn  <= DETW'(r1_p2) - DETW'(r1_p3);
            r2_dax <= r1_dax;
            r2_day <= r1_day;
            r2_asx <= r1_asx;
            r2_asy <= r1_asy;
            r2_box <= r1_box;
        end
    end

    // stage 3: partial products against split det and tn
    logic signed [HW-1:0] w_det_hi, w_tn_hi;
    logic signed [LW:0]   w_det_lo, w_tn_lo;
    assign w_det_hi = r2_det[DETW-1:LW];
    assign w_tn_hi  = r2_tn[DETW-1:LW];
    assign w_det_lo = $signed({1'b0, r2_det[LW-1:0]});
    assign w_tn_lo  = $signed({1'b0, r2_tn[LW-1:0]});

    logic                      r_v3;
    logic signed [C+HW-1:0]    r3_pxh, r3_pyh;
    logic signed [C+LW:0]      r3_pxl, r3_pyl;
    logic signed [DW+HW-1:0]   r3_qxh, r3_qyh;
    logic signed [DW+LW:0]     r3_qxl, r3_qyl;
    logic signed [DETW-1:0]    r3_det;
    logic                      r3_dz;
    logic [BXW-1:0]            r3_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_pxh <= r2_asx * w_det_hi;
            r3_pxl <= r2_asx * w_det_lo;
            r3_pyh <= r2_asy * w_det_hi;
            r3_pyl <= r2_asy * w_det_lo;
            r3_qxh <= r2_dax * w_tn_hi;
            r3_qxl <= r2_dax * w_tn_lo;
            r3_qyh <= r2_day * w_tn_hi;
            r3_qyl <= r2_day * w_tn_lo;
            r3_det <= r2_det;
            r3_dz  <= (r2_det == '0);
            r3_box <= r2_box;
        end
    end

    // stage 4: rejoin partial products
    logic                   r_v4;
    logic signed [NW-1:0]   r4_max, r4_may, r4_mbx, r4_mby;
    logic signed [DETW-1:0] r4_det;
    logic                   r4_dz;
    logic [BXW-1:0]         r4_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_max <= (NW'(r3_pxh) <<< LW) + NW'(r3_pxl);
            r4_may <= (NW'(r3_pyh) <<< LW) + NW'(r3_pyl);
            r4_mbx <= (NW'(r3_qxh) <<< LW) + NW'(r3_qxl);
            r4_mby <= (NW'(r3_qyh) <<< LW) + NW'(r3_qyl);
            r4_det <= r3_det;
            r4_dz  <= r3_dz;
            r4_box <= r3_box;
        end
    end

    // stage 5: point numerators
    logic                   r_v5;
    logic signed [NW-1:0]   r5_nx, r5_ny;
    logic signed [DETW-1:0] r5_det;
    logic                   r5_dz;
    logic [BXW-1:0]         r5_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nx  <= r4_max + r4_mbx;
            r5_ny  <= r4_may + r4_mby;
            r5_det <= r4_det;
            r5_dz  <= r4_dz;
            r5_box <= r4_box;
        end
    end

    // stage 6: magnitudes and quotient signs
    logic            r_v6;
    logic [NW-1:0]   r6_anx, r6_any;
    logic [DETW-1:0] r6_adet;
    logic            r6_negx, r6_negy, r6_dz;
    logic [BXW-1:0]  r6_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_anx  <= r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
            r6_any  <= r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
            r6_adet <= r5_det[DETW-1] ? DETW'(-r5_det) : DETW'(r5_det);
            r6_negx <= r5_nx[NW-1] ^ r5_det[DETW-1];
            r6_negy <= r5_ny[NW-1] ^ r5_det[DETW-1];
            r6_dz   <= r5_dz;
            r6_box  <= r5_box;
        end
    end

    // divider pipeline: index 0 is the range check stage, then one bit per stage
    logic [C:0]      r_dv_vld;
    logic [RW-1:0]   r_dv_remx [C+1];
    logic [RW-1:0]   r_dv_remy [C+1];
    logic [C-1:0]    r_dv_qx   [C+1];
    logic [C-1:0]    r_dv_qy   [C+1];
    logic [DETW-1:0] r_dv_adet [C+1];
    logic [3:0]      r_dv_flg  [C+1];   // negx, negy, bigx, bigy
    logic            r_dv_dz   [C+1];
    logic [BXW-1:0]  r_dv_box  [C+1];

    // quotient at or above 2^C always saturates
    logic [NW-1:0] w_dlim;
    assign w_dlim = NW'({r6_adet, {C{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_remx[0] <= r6_anx[RW-1:0];
            r_dv_remy[0] <= r6_any[RW-1:0];
            r_dv_qx[0]   <= '0;
            r_dv_qy[0]   <= '0;
            r_dv_adet[0] <= r6_adet;
            r_dv_flg[0]  <= {r6_negx, r6_negy, r6_anx >= w_dlim, r6_any >= w_dlim};
            r_dv_dz[0]   <= r6_dz;
            r_dv_box[0]  <= r6_box;
        end
    end

    for (genvar k = 0; k < C; k++) begin : g_div
        localparam int B = C - 1 - k;
        logic [RW-1:0] w_sh;
        logic [RW:0]   w_tx, w_ty;
        logic [C-1:0]  w_qx, w_qy;

        // trial subtract of the shifted divisor
        always_comb begin
            w_sh     = RW'(r_dv_adet[k]) << B;
            w_tx     = {1'b0, r_dv_remx[k]} - {1'b0, w_sh};
            w_ty     = {1'b0, r_dv_remy[k]} - {1'b0, w_sh};
            w_qx     = r_dv_qx[k];
            w_qy     = r_dv_qy[k];
            w_qx[B]  = !w_tx[RW];
            w_qy[B]  = !w_ty[RW];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_remx[k+1] <= w_tx[RW] ? r_dv_remx[k] : w_tx[RW-1:0];
                r_dv_remy[k+1] <= w_ty[RW] ? r_dv_remy[k] : w_ty[RW-1:0];
                r_dv_qx[k+1]   <= w_qx;
                r_dv_qy[k+1]   <= w_qy;
                r_dv_adet[k+1] <= r_dv_adet[k];
                r_dv_flg[k+1]  <= r_dv_flg[k];
                r_dv_dz[k+1]   <= r_dv_dz[k];
                r_dv_box[k+1]  <= r_dv_box[k];
            end
        end
    end

    // stage f: sign and saturation
    logic [C-1:0] w_qx, w_qy;
    logic         w_negx, w_negy, w_ovx, w_ovy;
    assign w_qx   = r_dv_qx[C];
    assign w_qy   = r_dv_qy[C];
    assign w_negx = r_dv_flg[C][3];
    assign w_negy = r_dv_flg[C][2];
    assign w_ovx  = r_dv_flg[C][1] || (w_qx[C-1] && !(w_negx && (w_qx[C-2:0] == '0)));
    assign w_ovy  = r_dv_flg[C][0] || (w_qy[C-1] && !(w_negy && (w_qy[C-2:0] == '0)));

    logic                r_vf;
    logic signed [C-1:0] rf_px, rf_py;
    logic                rf_ovf, rf_dz;
    logic [BXW-1:0]      rf_box;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_ovx) begin
                rf_px <= w_negx ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            end else begin
                rf_px <= w_negx ? -$signed(w_qx) : $signed(w_qx);
            end
            if (w_ovy) begin
                rf_py <= w_negy ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            end else begin
                rf_py <= w_negy ? -$signed(w_qy) : $signed(w_qy);
            end
            rf_ovf <= w_ovx || w_ovy;
            rf_dz  <= r_dv_dz[C];
            rf_box <= r_dv_box[C];
        end
    end

    // stage g: bounds test and parallel case
    logic                w_bnd;
    logic signed [C-1:0] w_xlo_ar, w_xhi_ar, w_ylo_ar, w_yhi_ar;
    logic signed [C-1:0] w_xlo_br, w_xhi_br, w_ylo_br, w_yhi_br;
    logic                w_inside;
    assign {w_bnd, w_xlo_ar, w_xhi_ar, w_ylo_ar, w_yhi_ar,
            w_xlo_br, w_xhi_br, w_ylo_br, w_yhi_br} = rf_box;
    assign w_inside = (rf_px >= w_xlo_ar) && (rf_px <= w_xhi_ar) &&
                      (rf_py >= w_ylo_ar) && (rf_py <= w_yhi_ar) &&
                      (rf_px >= w_xlo_br) && (rf_px <= w_xhi_br) &&
                      (rf_py >= w_ylo_br) && (rf_py <= w_yhi_br);

    logic                r_vg;
    logic signed [C-1:0] rg_px, rg_py;
    lsi_pkg::t_lsi_flags rg_flg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rg_px           <= rf_dz ? '0 : rf_px;
            rg_py           <= rf_dz ? '0 : rf_py;
            rg_flg.parallel <= rf_dz;
            rg_flg.overflow <= !rf_dz && rf_ovf;
            rg_flg.hit      <= !rf_dz && (!w_bnd || (!rf_ovf && w_inside));
        end
    end

    // valid bits of the fixed stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_vf        <= 1'b0;
            r_vg        <= 1'b0;
        end else if (en) begin
            r_v0        <= i_req.valid;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_v6        <= r_v5;
            r_dv_vld[0] <= r_v6;
            r_vf        <= r_dv_vld[C];
            r_vg        <= r_vf;
        end
    end

    // output register with one skid entry
    logic                r_out_vld;
    logic signed [C-1:0] r_out_px, r_out_py, r_sk_px, r_sk_py;
    lsi_pkg::t_lsi_flags r_out_flg, r_sk_flg;
    logic                w_pop, w_push;
    assign w_pop  = r_out_vld && o_res.ready;
    assign w_push = en && r_vg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (r_sk_vld) begin
            if (w_pop) begin
                r_sk_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_sk_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (w_pop) begin
                r_out_px  <= r_sk_px;
                r_out_py  <= r_sk_py;
                r_out_flg <= r_sk_flg;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                r_out_px  <= rg_px;
                r_out_py  <= rg_py;
                r_out_flg <= rg_flg;
            end else begin
                r_sk_px  <= rg_px;
                r_sk_py  <= rg_py;
                r_sk_flg <= rg_flg;
            end
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.point_x = r_out_px;
    assign o_res.point_y = r_out_py;
    assign o_res.flags   = r_out_flg;

    // skid entry is only used behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_out_vld)
        else $error("skid entry valid without output result");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_vld) |-> $past(r_out_vld && !o_res.ready))
        else $error("skid entry filled while output was free");

    // a parallel result carries no hit, no overflow and a zero point
    a_parallel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_flg.parallel) |->
            (!r_out_flg.hit && !r_out_flg.overflow && r_out_px == '0 && r_out_py == '0))
        else $error("parallel result with stray fields");

endmodule

`default_nettype wire

// ===== dv/tb_line_segment_intersection_core.sv =====
// tb_line_segment_intersection_core: checks the line intersection core against
// a wide-integer predictor of the point and flags; depends on lsi_pkg,
// lsi_in_if, lsi_out_if and line_segment_intersection_core
`timescale 1ns / 100ps

module tb_line_segment_intersection_core;

    localparam int CW = 32;
    localparam int LATENCY = CW + 11;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
        logic                 bounded;
    } t_lines;

    typedef struct packed {
        logic signed [CW-1:0] px, py;
        lsi_pkg::t_lsi_flags  flags;
    } t_point;

    logic i_clk;
    logic i_rst_n;

    lsi_in_if  #(.COORD_WIDTH(CW)) req_if ();
    lsi_out_if #(.COORD_WIDTH(CW)) res_if ();

    line_segment_intersection_core #(.COORD_WIDTH(CW)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    t_lines pending_lines[$];
    t_point expected_points[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_send;
    int     mismatches;
    longint cycle_count;
    int     results_seen;
    int     hits_seen;
    int     parallels_seen;
    int     overflows_seen;

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // saturating truncated division of exact wide integers
    function automatic logic signed [CW-1:0] sat_quot(logic signed [199:0] num,
            logic signed [199:0] den, inout bit ovf);
        logic signed [199:0] q;
        q = num / den;
        if (q > 200'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -200'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return q[CW-1:0];
    endfunction

    function automatic bit between(logic signed [CW-1:0] v, logic signed [CW-1:0] e0,
            logic signed [CW-1:0] e1);
        if (e0 < e1) return v >= e0 && v <= e1;
        return v >= e1 && v <= e0;
    endfunction

    // intersection point via the cross-product determinant
    function automatic t_point compute_point(t_lines l);
        logic signed [199:0] dax, day, dbx, dby, det, tn, nx, ny;
        t_point r;
        bit ovf;
        ovf = 1'b0;
        r = '0;
        dax = 200'(l.aex) - 200'(l.asx);
        day = 200'(l.aey) - 200'(l.asy);
        dbx = 200'(l.bex) - 200'(l.bsx);
        dby = 200'(l.bey) - 200'(l.bsy);
        det = dax * dby - day * dbx;
        if (det == 0) begin
            r.flags.parallel = 1'b1;
            return r;
        end
        tn = (200'(l.bsx) - 200'(l.asx)) * dby - (200'(l.bsy) - 200'(l.asy)) * dbx;
        nx = 200'(l.asx) * det + dax * tn;
        ny = 200'(l.asy) * det + day * tn;
        r.px = sat_quot(nx, det, ovf);
        r.py = sat_quot(ny, det, ovf);
        r.flags.overflow = ovf;
        if (!l.bounded) begin
            r.flags.hit = 1'b1;
        end else begin
            r.flags.hit = !ovf && between(r.px, l.asx, l.aex) && between(r.py, l.asy, l.aey)
                && between(r.px, l.bsx, l.bex) && between(r.py, l.bsy, l.bey);
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed(CW'($urandom_range(0, 2000))) - 1000;
            2: return $signed(CW'($urandom_range(0, 32'h00200000))) - 32'sh00100000;
            default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    // random pair of lines, biased toward small coordinates that meet in range
    function automatic t_lines rand_lines();
        t_lines l;
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) k = 0; else if (k < 5) k = 1; else if (k < 9) k = 2; else k = 3;
        l.asx = rand_coord(k);
        l.asy = rand_coord(k);
        l.aex = rand_coord(k);
        l.aey = rand_coord(k);
        l.bsx = rand_coord(k);
        l.bsy = rand_coord(k);
        l.bex = rand_coord(k);
        l.bey = rand_coord(k);
        // now and then a parallel or degenerate pair
        case ($urandom_range(0, 11))
            0: begin
                l.bex = l.bsx + (l.aex - l.asx);
                l.bey = l.bsy + (l.aey - l.asy);
            end
            1: begin
                l.aex = l.asx;
                l.aey = l.asy;
            end
            default: ;
        endcase
        l.bounded = 1'($urandom_range(0, 1));
        return l;
    endfunction

    function automatic t_lines make_lines(int asx, int asy, int aex, int aey, int bsx,
            int bsy, int bex, int bey, bit bounded);
        t_lines l;
        l = {asx, asy, aex, aey, bsx, bsy, bex, bey, bounded};
        return l;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_lines.size() > 0 && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                t_lines l;
                l = pending_lines.pop_front();
                expected_points.push_back(compute_point(l));
                req_if.valid     <= 1'b1;
                req_if.a_start_x <= l.asx;
                req_if.a_start_y <= l.asy;
                req_if.a_end_x   <= l.aex;
                req_if.a_end_y   <= l.aey;
                req_if.b_start_x <= l.bsx;
                req_if.b_start_y <= l.bsy;
                req_if.b_end_x   <= l.bex;
                req_if.b_end_y   <= l.bey;
                req_if.bounded   <= l.bounded;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and ready pattern
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                t_point got;
                t_point want;
                got = {res_if.point_x, res_if.point_y, res_if.flags};
                results_seen <= results_seen + 1;
                if (expected_points.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h, expected none", got);
                end else begin
                    want = expected_points.pop_front();
                    hits_seen      <= hits_seen + want.flags.hit;
                    parallels_seen <= parallels_seen + want.flags.parallel;
                    overflows_seen <= overflows_seen + want.flags.overflow;
                    if (got.px !== want.px || got.py !== want.py
                            || got.flags !== want.flags) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("mismatch: expected x=%h y=%h hit=%b par=%b ovf=%b",
                                want.px, want.py, want.flags.hit, want.flags.parallel,
                                want.flags.overflow);
                            $display("          got      x=%h y=%h hit=%b par=%b ovf=%b",
                                got.px, got.py, got.flags.hit, got.flags.parallel,
                                got.flags.overflow);
                        end
                    end
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_lines.size() > 0 || req_if.valid || expected_points.size() > 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int phase;
        req_if.valid = 1'b0;
        req_if.a_start_x = '0;
        req_if.a_start_y = '0;
        req_if.a_end_x = '0;
        req_if.a_end_y = '0;
        req_if.b_start_x = '0;
        req_if.b_start_y = '0;
        req_if.b_end_x = '0;
        req_if.b_end_y = '0;
        req_if.bounded = 1'b0;
        res_if.ready = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 47;
        hold_send = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        results_seen = 0;
        hits_seen = 0;
        parallels_seen = 0;
        overflows_seen = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: crossing, bounds edges, parallel, degenerate, saturation
        pending_lines.push_back(make_lines(0, 0, 65536, 65536, 0, 65536, 65536, 0, 1));
        pending_lines.push_back(make_lines(0, 0, 65536, 65536, 0, 65536, 65536, 0, 0));
        pending_lines.push_back(make_lines(0, 0, 10, 0, 10, -5, 10, 5, 1));
        pending_lines.push_back(make_lines(0, 0, 10, 0, 11, -5, 11, 5, 1));
        pending_lines.push_back(make_lines(0, 0, 10, 0, 11, -5, 11, 5, 0));
        pending_lines.push_back(make_lines(0, 0, 10, 10, 0, 5, 10, 15, 0));
        pending_lines.push_back(make_lines(0, 0, 10, 10, 20, 20, 30, 30, 1));
        pending_lines.push_back(make_lines(3, 3, 3, 3, 0, 0, 5, 7, 0));
        pending_lines.push_back(make_lines(0, 0, 1, 0, 0, 0, 0, 1, 1));
        pending_lines.push_back(make_lines(0, 0, 1, 1, 0, 1, 1, 2 + 1 - 1, 0));
        pending_lines.push_back(make_lines(0, 0, 1, 1, 0, 1, 2, 2, 0));
        pending_lines.push_back(make_lines(0, 0, 1, 1, 0, 1, 2, 2, 1));
        pending_lines.push_back(make_lines(-7, 3, 5, -2, 1, 9, -3, -8, 1));
        pending_lines.push_back(make_lines(32'h7fffffff, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1));
        pending_lines.push_back(make_lines(32'h7fffffff, 32'h7fffffff, 32'h80000000,
            32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0));
        pending_lines.push_back(make_lines(0, 0, 32'h7fffffff, 1, 0, 5, 32'h7fffffff, 4, 0));
        pending_lines.push_back(make_lines(32'h80000000, 0, 32'h80000000, 1, 0, 0, 1, 0, 1));
        pending_lines.push_back(make_lines(-1, -1, -1, -1, -1, -1, -1, -1, 1));
        pending_lines.push_back(make_lines(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_lines.push_back(make_lines(5, -3, -5, 3, -5, -3, 5, 3, 0));

        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 47;
                recv_idle_pct = 16;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (310) pending_lines.push_back(rand_lines());
            // sender holds off until the pipeline is empty
            while (pending_lines.size() > 0 || req_if.valid) @(posedge i_clk);
            hold_send = 1'b1;
            wait_drained();
            hold_send = 1'b0;
            repeat (340) pending_lines.push_back(rand_lines());
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d results: %0d hits, %0d parallel, %0d saturated",
            results_seen, hits_seen, parallels_seen, overflows_seen);
        $display("idle mixes: sender 16/receiver 47, sender 47/receiver 16, none");
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                expected_points.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
